FILE: rtl/core/acfd_pkg.sv
// ----------------------------------------------------------------------------
// acfd_pkg
// Shared types and constants for the arm CAN feedback decoder.
// ----------------------------------------------------------------------------
package acfd_pkg;

  localparam int unsigned JOINT_COUNT   = 7;
  localparam int unsigned TIME_BITS_DEF = 64;
  localparam int unsigned QUEUE_DEPTH   = 2;

  localparam int unsigned ID_BITS    = 11;
  localparam int unsigned LEN_BITS   = 4;
  localparam int unsigned DATA_BITS  = 64;
  localparam int unsigned CFG_IDX_BITS = 3;

  localparam logic [LEN_BITS-1:0] DECODE_LENGTH = 4'd8;

  localparam logic [ID_BITS-1:0] DRIVER_ID_FIRST = 11'h261;
  localparam logic [ID_BITS-1:0] DRIVER_ID_LAST  = 11'h267;

  localparam logic [ID_BITS-1:0] PAIR12_ID_RST  = 11'd677;
  localparam logic [ID_BITS-1:0] PAIR34_ID_RST  = 11'd678;
  localparam logic [ID_BITS-1:0] PAIR56_ID_RST  = 11'd679;
  localparam logic [ID_BITS-1:0] SINGLE7_ID_RST = 11'd680;
  localparam logic [ID_BITS-1:0] GRIPPER_ID_RST = 11'd681;

  localparam logic [7:0] ENABLE_BIT        = 8'h40;
  localparam logic [7:0] DRIVER_FAULT_MASK = 8'hBF;
  localparam logic [7:0] GRIP_FAULT_MASK   = 8'h3F;
  localparam logic [7:0] HOMED_BIT         = 8'h80;
  localparam logic [3:0] ALL_ARRIVED       = 4'hF;

  localparam logic [2:0] SLOT_PAIR12  = 3'd0;
  localparam logic [2:0] SLOT_PAIR34  = 3'd2;
  localparam logic [2:0] SLOT_PAIR56  = 3'd4;
  localparam logic [2:0] SLOT_SINGLE7 = 3'd6;

  localparam logic [CFG_IDX_BITS-1:0] CFG_PAIR12  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PAIR34  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PAIR56  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SINGLE7 = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GRIPPER = 3'd4;

  typedef enum logic [1:0] {
    KIND_IGNORED = 2'd0,
    KIND_JOINT   = 2'd1,
    KIND_DRIVER  = 2'd2,
    KIND_GRIPPER = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [2:0]         slot;
    logic               pair;
    logic [1:0]         pos_bit;
    logic signed [31:0] value_first;
    logic signed [31:0] value_second;
    logic [15:0]        force_val;
    logic [7:0]         status;
    logic               enabled;
    logic               fault;
    logic               homed;
  } item_t;

  typedef struct packed {
    kind_e              kind;
    logic [2:0]         slot;
    logic signed [31:0] value_first;
    logic signed [31:0] value_second;
    logic               pair;
    logic [15:0]        force_val;
    logic [7:0]         status;
    logic               enabled;
    logic               fault;
    logic               homed;
    logic               cycle_complete;
    logic [31:0]        cycle_count;
  } result_t;

endpackage

FILE: rtl/core/arm_can_feedback_decoder_top.sv
// ----------------------------------------------------------------------------
// arm_can_feedback_decoder_top
// Decodes received arm CAN frames into joint, driver and gripper results.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one received frame per
//   beat: id, length code, eight payload bytes and a timestamp. Every beat
//   yields exactly one result beat on out_valid_o / out_stall_i, in order;
//   frames of other length or unknown id give a result of kind ignored.
//   Id registers are written through cfg_we_i / cfg_index_i / cfg_data_i;
//   the user must do so only while the block is idle, the block does not
//   enforce it; writes beyond the last index are dropped. Throughput: one
//   frame per cycle unless a stall holds the flow. A frame passes from the
//   classifier into a two-entry queue, then via the state update into the
//   output register; the position-cycle counter loop sets the rate.
//   When the receiver stalls, the output register holds its beat and the
//   queue absorbs up to two more frames before in_stall_o rises.
//   Reset clears all joint, driver and gripper state, the arrival mask and
//   the cycle count, and restores the default feedback ids.
// ----------------------------------------------------------------------------
module arm_can_feedback_decoder_top #(
  parameter int unsigned TimeBits = acfd_pkg::TIME_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [acfd_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [acfd_pkg::ID_BITS-1:0]      cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [acfd_pkg::ID_BITS-1:0]      frame_id_i,
  input  logic [acfd_pkg::LEN_BITS-1:0]     frame_length_i,
  input  logic [acfd_pkg::DATA_BITS-1:0]    frame_data_i,
  input  logic [63:0]                       frame_time_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        frame_kind_o,
  output logic [2:0]                        joint_slot_o,
  output logic signed [31:0]                value_first_o,
  output logic signed [31:0]                value_second_o,
  output logic                              pair_written_o,
  output logic [15:0]                       force_millinewton_o,
  output logic [7:0]                        status_byte_o,
  output logic                              enabled_flag_o,
  output logic                              fault_flag_o,
  output logic                              homed_flag_o,
  output logic                              cycle_complete_o,
  output logic [31:0]                       cycle_count_o
);
  import acfd_pkg::*;

  item_t               front_item, q_item;
  logic [TimeBits-1:0] front_time, q_time;
  logic                q_full, q_valid, q_pop, push;
  result_t             res;

  assign in_stall_o = q_full;
  assign push       = in_valid_i && !q_full;

  acfd_front #(.TimeBits(TimeBits)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .frame_id_i     (frame_id_i),
    .frame_length_i (frame_length_i),
    .frame_data_i   (frame_data_i),
    .frame_time_i   (frame_time_i),
    .item_o         (front_item),
    .time_o         (front_time)
  );

  acfd_queue #(.TimeBits(TimeBits)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .time_i  (front_time),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item),
    .time_o  (q_time)
  );

  acfd_back #(.TimeBits(TimeBits)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .item_i      (q_item),
    .time_i      (q_time),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign frame_kind_o        = res.kind;
  assign joint_slot_o        = res.slot;
  assign value_first_o       = res.value_first;
  assign value_second_o      = res.value_second;
  assign pair_written_o      = res.pair;
  assign force_millinewton_o = res.force_val;
  assign status_byte_o       = res.status;
  assign enabled_flag_o      = res.enabled;
  assign fault_flag_o        = res.fault;
  assign homed_flag_o        = res.homed;
  assign cycle_complete_o    = res.cycle_complete;
  assign cycle_count_o       = res.cycle_count;

`ifndef SYNTHESIS
  a_complete_is_joint : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cycle_complete_o |-> frame_kind_o == KIND_JOINT)
    else $error("cycle completion on a non-position beat");

  a_pair_not_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pair_written_o |-> frame_kind_o == KIND_JOINT && joint_slot_o != SLOT_SINGLE7)
    else $error("pair write flagged on a single or non-position beat");

  a_ignored_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_kind_o == KIND_IGNORED |->
      value_first_o == '0 && value_second_o == '0 && !pair_written_o && !enabled_flag_o
      && !fault_flag_o && !homed_flag_o && !cycle_complete_o)
    else $error("ignored beat carries decoded fields");

  a_count_steps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop && out_valid_o && !out_stall_i |=>
      cycle_count_o == $past(cycle_count_o) + 32'(cycle_complete_o))
    else $error("cycle count did not advance with completion");
`endif

endmodule

FILE: rtl/core/acfd_front.sv
// ----------------------------------------------------------------------------
// acfd_front
// Holds the id registers and classifies each incoming frame into a decoded
// item with its extracted fields.
// ----------------------------------------------------------------------------
module acfd_front #(
  parameter int unsigned TimeBits = acfd_pkg::TIME_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [acfd_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [acfd_pkg::ID_BITS-1:0]         cfg_data_i,
  input  logic [acfd_pkg::ID_BITS-1:0]         frame_id_i,
  input  logic [acfd_pkg::LEN_BITS-1:0]        frame_length_i,
  input  logic [acfd_pkg::DATA_BITS-1:0]       frame_data_i,
  input  logic [63:0]                          frame_time_i,
  output acfd_pkg::item_t                      item_o,
  output logic [TimeBits-1:0]                  time_o
);
  import acfd_pkg::*;

  logic [ID_BITS-1:0] pair12_id_q, pair34_id_q, pair56_id_q, single7_id_q, gripper_id_q;
  logic [7:0]         drv_status;
  logic [7:0]         grip_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair12_id_q  <= PAIR12_ID_RST;
      pair34_id_q  <= PAIR34_ID_RST;
      pair56_id_q  <= PAIR56_ID_RST;
      single7_id_q <= SINGLE7_ID_RST;
      gripper_id_q <= GRIPPER_ID_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PAIR12:  pair12_id_q  <= cfg_data_i;
        CFG_PAIR34:  pair34_id_q  <= cfg_data_i;
        CFG_PAIR56:  pair56_id_q  <= cfg_data_i;
        CFG_SINGLE7: single7_id_q <= cfg_data_i;
        CFG_GRIPPER: gripper_id_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign drv_status  = frame_data_i[23:16];
  assign grip_status = frame_data_i[15:8];
  assign time_o      = frame_time_i[TimeBits-1:0];

  always_comb begin
    item_o = '0;
    item_o.kind = KIND_IGNORED;
    if (frame_length_i == DECODE_LENGTH) begin
      priority if (frame_id_i == pair12_id_q) begin
        item_o.kind = KIND_JOINT;
        item_o.slot = SLOT_PAIR12;
        item_o.pair = 1'b1;
      end else if (frame_id_i == pair34_id_q) begin
        item_o.kind = KIND_JOINT;
        item_o.slot = SLOT_PAIR34;
        item_o.pair = 1'b1;
      end else if (frame_id_i == pair56_id_q) begin
        item_o.kind = KIND_JOINT;
        item_o.slot = SLOT_PAIR56;
        item_o.pair = 1'b1;
      end else if (frame_id_i == single7_id_q) begin
        item_o.kind = KIND_JOINT;
        item_o.slot = SLOT_SINGLE7;
      end else if (frame_id_i >= DRIVER_ID_FIRST && frame_id_i <= DRIVER_ID_LAST) begin
        item_o.kind    = KIND_DRIVER;
        item_o.slot    = 3'(frame_id_i - DRIVER_ID_FIRST);
        item_o.status  = drv_status;
        item_o.enabled = |(drv_status & ENABLE_BIT);
        item_o.fault   = |(drv_status & DRIVER_FAULT_MASK);
      end else if (frame_id_i == gripper_id_q) begin
        item_o.kind         = KIND_GRIPPER;
        item_o.value_first  = frame_data_i[63:32];
        item_o.value_second = {24'd0, frame_data_i[7:0]};
        item_o.force_val    = frame_data_i[31:16];
        item_o.status       = grip_status;
        item_o.enabled      = |(grip_status & ENABLE_BIT);
        item_o.fault        = |(grip_status & GRIP_FAULT_MASK);
        item_o.homed        = |(grip_status & HOMED_BIT);
      end else begin
        item_o.kind = KIND_IGNORED;
      end
      if (item_o.kind == KIND_JOINT) begin
        item_o.pos_bit     = item_o.slot[2:1];
        item_o.value_first = frame_data_i[63:32];
        if (item_o.pair) begin
          item_o.value_second = frame_data_i[31:0];
        end
      end
    end
  end

endmodule

FILE: rtl/core/acfd_queue.sv
// ----------------------------------------------------------------------------
// acfd_queue
// Short queue between the classifier and the state update; decouples the
// stall of each side.
// ----------------------------------------------------------------------------
module acfd_queue #(
  parameter int unsigned TimeBits = acfd_pkg::TIME_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  acfd_pkg::item_t     item_i,
  input  logic [TimeBits-1:0] time_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output acfd_pkg::item_t     item_o,
  output logic [TimeBits-1:0] time_o
);
  import acfd_pkg::*;

  localparam int unsigned PtrBits = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntBits = $clog2(QUEUE_DEPTH + 1);

  item_t               item_mem [QUEUE_DEPTH];
  logic [TimeBits-1:0] time_mem [QUEUE_DEPTH];
  logic [PtrBits-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0]  count_q;

  assign full_o  = (count_q == CntBits'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = item_mem[rd_ptr_q];
  assign time_o  = time_mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      item_mem[wr_ptr_q] <= item_i;
      time_mem[wr_ptr_q] <= time_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrBits'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrBits'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/acfd_back.sv
// ----------------------------------------------------------------------------
// acfd_back
// Applies decoded items to the joint and gripper state, tracks the position
// cycle and holds the result beat for the receiver.
// ----------------------------------------------------------------------------
module acfd_back #(
  parameter int unsigned TimeBits = acfd_pkg::TIME_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  acfd_pkg::item_t     item_i,
  input  logic [TimeBits-1:0] time_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output acfd_pkg::result_t   res_o
);
  import acfd_pkg::*;

  logic [31:0]         joint_angle_q [JOINT_COUNT];
  logic [JOINT_COUNT-1:0] angle_valid_q, driver_seen_q, motor_on_q, motor_fault_q;
  logic [3:0]          arrival_mask_q, mask_set;
  logic [31:0]         seq_q, seq_d;
  logic [TimeBits-1:0] last_arm_time_q, cycle_time_q, grip_time_q;
  logic [31:0]         grip_width_q;
  logic [15:0]         grip_force_q;
  logic [7:0]          grip_status_q, grip_mode_q;
  logic                done;
  logic                valid_q;
  result_t             res_q, res_d;

  assign pop_o       = q_valid_i && (!valid_q || !out_stall_i);
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_comb begin
    mask_set = arrival_mask_q | (4'b0001 << item_i.pos_bit);
    done     = (item_i.kind == KIND_JOINT) && (mask_set == ALL_ARRIVED);
    seq_d    = seq_q + 32'(done);
    res_d.kind           = item_i.kind;
    res_d.slot           = item_i.slot;
    res_d.value_first    = item_i.value_first;
    res_d.value_second   = item_i.value_second;
    res_d.pair           = item_i.pair;
    res_d.force_val      = item_i.force_val;
    res_d.status         = item_i.status;
    res_d.enabled        = item_i.enabled;
    res_d.fault          = item_i.fault;
    res_d.homed          = item_i.homed;
    res_d.cycle_complete = done;
    res_d.cycle_count    = seq_d;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q         <= 1'b0;
      joint_angle_q   <= '{default: '0};
      angle_valid_q   <= '0;
      driver_seen_q   <= '0;
      motor_on_q      <= '0;
      motor_fault_q   <= '0;
      arrival_mask_q  <= '0;
      seq_q           <= '0;
      last_arm_time_q <= '0;
      cycle_time_q    <= '0;
      grip_width_q    <= '0;
      grip_force_q    <= '0;
      grip_status_q   <= '0;
      grip_mode_q     <= '0;
      grip_time_q     <= '0;
    end else begin
      valid_q <= pop_o || (valid_q && out_stall_i);
      if (pop_o) begin
        unique case (item_i.kind)
          KIND_JOINT: begin
            joint_angle_q[item_i.slot] <= item_i.value_first;
            angle_valid_q[item_i.slot] <= 1'b1;
            if (item_i.pair) begin
              joint_angle_q[item_i.slot + 3'd1] <= item_i.value_second;
              angle_valid_q[item_i.slot + 3'd1] <= 1'b1;
            end
            last_arm_time_q <= time_i;
            seq_q           <= seq_d;
            if (done) begin
              arrival_mask_q <= '0;
              cycle_time_q   <= time_i;
            end else begin
              arrival_mask_q <= mask_set;
            end
          end
          KIND_DRIVER: begin
            driver_seen_q[item_i.slot] <= 1'b1;
            motor_on_q[item_i.slot]    <= item_i.enabled;
            motor_fault_q[item_i.slot] <= item_i.fault;
            last_arm_time_q            <= time_i;
          end
          KIND_GRIPPER: begin
            grip_width_q  <= item_i.value_first;
            grip_force_q  <= item_i.force_val;
            grip_status_q <= item_i.status;
            grip_mode_q   <= item_i.value_second[7:0];
            grip_time_q   <= time_i;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: tb/sv/tb_arm_can_feedback_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_arm_can_feedback_decoder_top
// Self-checking bench for the arm CAN feedback decoder. A table of directed
// frames covers lengths, id edges, driver and gripper status extremes and a
// full position cycle; random frames follow under four id settings,
// including overlapping ids. A local decoder model predicts the result beats
// that rows do not fix; random idling and stalling exercise both handshakes.
// ----------------------------------------------------------------------------
module tb_arm_can_feedback_decoder_top;
  import acfd_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT   = 500;
  localparam int unsigned LONG_HOLD_CYCLES = 40;
  localparam int unsigned SETTLE_CYCLES    = 6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FIRST_UNUSED = 3'd5;

  typedef struct {
    logic [ID_BITS-1:0]   id;
    logic [LEN_BITS-1:0]  len;
    logic [DATA_BITS-1:0] data;
    logic [63:0]          stamp;
    bit                   fixed_want;
    result_t              want;
  } frame_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_BITS-1:0] cfg_index_i;
  logic [ID_BITS-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_stall_o;
  logic [ID_BITS-1:0] frame_id_i;
  logic [LEN_BITS-1:0] frame_length_i;
  logic [DATA_BITS-1:0] frame_data_i;
  logic [63:0] frame_time_i;
  logic out_valid_o;
  logic out_stall_i;
  logic [1:0] frame_kind_o;
  logic [2:0] joint_slot_o;
  logic signed [31:0] value_first_o;
  logic signed [31:0] value_second_o;
  logic pair_written_o;
  logic [15:0] force_millinewton_o;
  logic [7:0] status_byte_o;
  logic enabled_flag_o;
  logic fault_flag_o;
  logic homed_flag_o;
  logic cycle_complete_o;
  logic [31:0] cycle_count_o;

  logic [ID_BITS-1:0] feedback_ids [5] =
    '{PAIR12_ID_RST, PAIR34_ID_RST, PAIR56_ID_RST, SINGLE7_ID_RST, GRIPPER_ID_RST};
  logic signed [31:0] joint_mdeg [JOINT_COUNT] = '{default: '0};
  logic joint_known [JOINT_COUNT] = '{default: 1'b0};
  logic motor_on [JOINT_COUNT] = '{default: 1'b0};
  logic motor_fault [JOINT_COUNT] = '{default: 1'b0};
  logic [3:0] arrivals = '0;
  logic [31:0] cycle_seq = '0;
  logic [63:0] arm_stamp = '0;
  logic [63:0] cycle_stamp = '0;
  logic [31:0] grip_width = '0;
  logic [15:0] grip_force = '0;
  logic [7:0] grip_status = '0;
  logic [7:0] grip_mode = '0;
  logic [63:0] grip_stamp = '0;

  frame_row_t directed_rows [$];
  result_t pending_results [$];
  result_t seen_want;
  int error_count = 0;
  int kind_count [4] = '{default: 0};
  int cycles_done = 0;
  int quiet_cycles = 0;
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;
  bit hold_off_request = 1'b0;

  arm_can_feedback_decoder_top i_dut (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o,
    .frame_id_i, .frame_length_i, .frame_data_i, .frame_time_i,
    .out_valid_o, .out_stall_i,
    .frame_kind_o, .joint_slot_o, .value_first_o, .value_second_o,
    .pair_written_o, .force_millinewton_o, .status_byte_o,
    .enabled_flag_o, .fault_flag_o, .homed_flag_o,
    .cycle_complete_o, .cycle_count_o
  );

  always #4 clk_i = ~clk_i;

  function automatic result_t predict_feedback(input frame_row_t f);
    result_t r;
    logic [2:0] slot;
    logic hit;
    logic paired;
    logic [7:0] st;
    logic [ID_BITS-1:0] drv;
    r = '0;
    r.kind = KIND_IGNORED;
    hit = 1'b1;
    paired = 1'b1;
    slot = SLOT_PAIR12;
    if (f.len == DECODE_LENGTH) begin
      if (f.id == feedback_ids[CFG_PAIR12]) slot = SLOT_PAIR12;
      else if (f.id == feedback_ids[CFG_PAIR34]) slot = SLOT_PAIR34;
      else if (f.id == feedback_ids[CFG_PAIR56]) slot = SLOT_PAIR56;
      else if (f.id == feedback_ids[CFG_SINGLE7]) begin
        slot = SLOT_SINGLE7;
        paired = 1'b0;
      end else hit = 1'b0;
      if (hit) begin
        r.kind = KIND_JOINT;
        r.slot = slot;
        r.value_first = f.data[63:32];
        joint_mdeg[slot] = f.data[63:32];
        joint_known[slot] = 1'b1;
        if (paired) begin
          r.value_second = f.data[31:0];
          r.pair = 1'b1;
          joint_mdeg[slot+1] = f.data[31:0];
          joint_known[slot+1] = 1'b1;
        end
        arm_stamp = f.stamp;
        arrivals[slot[2:1]] = 1'b1;
        if (arrivals == ALL_ARRIVED) begin
          arrivals = '0;
          cycle_stamp = f.stamp;
          cycle_seq = cycle_seq + 32'd1;
          r.cycle_complete = 1'b1;
        end
      end else if (f.id >= DRIVER_ID_FIRST && f.id <= DRIVER_ID_LAST) begin
        st = f.data[23:16];
        drv = f.id - DRIVER_ID_FIRST;
        motor_on[drv] = |(st & ENABLE_BIT);
        motor_fault[drv] = |(st & DRIVER_FAULT_MASK);
        arm_stamp = f.stamp;
        r.kind = KIND_DRIVER;
        r.slot = drv[2:0];
        r.status = st;
        r.enabled = motor_on[drv];
        r.fault = motor_fault[drv];
      end else if (f.id == feedback_ids[CFG_GRIPPER]) begin
        grip_width = f.data[63:32];
        grip_force = f.data[31:16];
        grip_status = f.data[15:8];
        grip_mode = f.data[7:0];
        grip_stamp = f.stamp;
        r.kind = KIND_GRIPPER;
        r.value_first = grip_width;
        r.value_second = {24'd0, grip_mode};
        r.force_val = grip_force;
        r.status = grip_status;
        r.enabled = |(grip_status & ENABLE_BIT);
        r.fault = |(grip_status & GRIP_FAULT_MASK);
        r.homed = |(grip_status & HOMED_BIT);
      end
    end
    r.cycle_count = cycle_seq;
    return r;
  endfunction

  function automatic frame_row_t random_frame();
    frame_row_t f;
    int unsigned pick;
    f = '{default: '0};
    pick = $urandom_range(0, 99);
    if (pick < 55) f.id = feedback_ids[$urandom_range(CFG_PAIR12, CFG_SINGLE7)];
    else if (pick < 70) f.id = DRIVER_ID_FIRST + ID_BITS'($urandom_range(0, 6));
    else if (pick < 80) f.id = feedback_ids[CFG_GRIPPER];
    else f.id = ID_BITS'($urandom);
    f.len = ($urandom_range(0, 9) == 0) ? LEN_BITS'($urandom) : DECODE_LENGTH;
    case ($urandom_range(0, 9))
      0: f.data = '0;
      1: f.data = '1;
      default: f.data = {$urandom, $urandom};
    endcase
    f.stamp = {$urandom, $urandom};
    return f;
  endfunction

  task automatic add_row(input logic [ID_BITS-1:0] id, input logic [LEN_BITS-1:0] len,
                         input logic [DATA_BITS-1:0] data, input logic [63:0] stamp,
                         input bit fixed_want, input result_t want);
    frame_row_t f;
    f.id = id;
    f.len = len;
    f.data = data;
    f.stamp = stamp;
    f.fixed_want = fixed_want;
    f.want = want;
    directed_rows.push_back(f);
  endtask

  task automatic send_frame(input frame_row_t f);
    result_t want;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    frame_id_i <= f.id;
    frame_length_i <= f.len;
    frame_data_i <= f.data;
    frame_time_i <= f.stamp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    want = predict_feedback(f);
    if (f.fixed_want) want = f.want;
    pending_results.push_back(want);
    kind_count[want.kind]++;
    if (want.cycle_complete) cycles_done++;
  endtask

  task automatic run_random(input int count);
    repeat (count) send_frame(random_frame());
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_ids(input logic [ID_BITS-1:0] p12, input logic [ID_BITS-1:0] p34,
                         input logic [ID_BITS-1:0] p56, input logic [ID_BITS-1:0] s7,
                         input logic [ID_BITS-1:0] grip);
    logic [ID_BITS-1:0] vals [5];
    logic [CFG_IDX_BITS-1:0] regs [5];
    vals = '{p12, p34, p56, s7, grip};
    regs = '{CFG_PAIR12, CFG_PAIR34, CFG_PAIR56, CFG_SINGLE7, CFG_GRIPPER};
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_FIRST_UNUSED + CFG_IDX_BITS'($urandom_range(0, 2));
    cfg_data_i <= ID_BITS'($urandom);
    @(posedge clk_i);
    for (int k = 0; k < 5; k++) begin
      cfg_index_i <= regs[k];
      cfg_data_i <= vals[k];
      feedback_ids[regs[k]] = vals[k];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: result beat with no frame pending", $time);
      end else begin
        seen_want = pending_results.pop_front();
        check_field("frame_kind", seen_want.kind, frame_kind_o);
        check_field("joint_slot", seen_want.slot, joint_slot_o);
        check_field("value_first", seen_want.value_first, value_first_o);
        check_field("value_second", seen_want.value_second, value_second_o);
        check_field("pair_written", seen_want.pair, pair_written_o);
        check_field("force_millinewton", seen_want.force_val, force_millinewton_o);
        check_field("status_byte", seen_want.status, status_byte_o);
        check_field("enabled_flag", seen_want.enabled, enabled_flag_o);
        check_field("fault_flag", seen_want.fault, fault_flag_o);
        check_field("homed_flag", seen_want.homed, homed_flag_o);
        check_field("cycle_complete", seen_want.cycle_complete, cycle_complete_o);
        check_field("cycle_count", seen_want.cycle_count, cycle_count_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    frame_id_i = '0;
    frame_length_i = '0;
    frame_data_i = '0;
    frame_time_i = '0;

    add_row(PAIR12_ID_RST, 4'd0, '1, '0, 1'b1, '{kind: KIND_IGNORED, default: '0});
    add_row(PAIR12_ID_RST, 4'hF, '1, '1, 1'b1, '{kind: KIND_IGNORED, default: '0});
    add_row(11'h000, DECODE_LENGTH, '1, 64'd5, 1'b1, '{kind: KIND_IGNORED, default: '0});
    add_row(11'h7FF, DECODE_LENGTH, '0, 64'd6, 1'b1, '{kind: KIND_IGNORED, default: '0});
    add_row(PAIR12_ID_RST, DECODE_LENGTH, 64'h80000000_7FFFFFFF, 64'd1, 1'b1,
            '{kind: KIND_JOINT, slot: SLOT_PAIR12, value_first: 32'h80000000,
              value_second: 32'h7FFFFFFF, pair: 1'b1, default: '0});
    add_row(PAIR34_ID_RST, DECODE_LENGTH, 64'hFFFFFFFF_00000000, 64'd2, 1'b1,
            '{kind: KIND_JOINT, slot: SLOT_PAIR34, value_first: 32'hFFFFFFFF,
              pair: 1'b1, default: '0});
    add_row(PAIR56_ID_RST, DECODE_LENGTH, 64'h00000000_FFFFFFFF, 64'd3, 1'b0, '0);
    add_row(SINGLE7_ID_RST, DECODE_LENGTH, 64'h12345678_9ABCDEF0, '1, 1'b1,
            '{kind: KIND_JOINT, slot: SLOT_SINGLE7, value_first: 32'h12345678,
              cycle_complete: 1'b1, cycle_count: 32'd1, default: '0});
    add_row(SINGLE7_ID_RST, DECODE_LENGTH, 64'h0BADF00D_CAFE1234, 64'd9, 1'b0, '0);
    add_row(DRIVER_ID_FIRST, DECODE_LENGTH, 64'h00000000_00FF0000, 64'd10, 1'b1,
            '{kind: KIND_DRIVER, slot: 3'd0, status: 8'hFF, enabled: 1'b1,
              fault: 1'b1, cycle_count: 32'd1, default: '0});
    add_row(DRIVER_ID_LAST, DECODE_LENGTH, 64'hFFFFFFFF_FF40FFFF, 64'd11, 1'b1,
            '{kind: KIND_DRIVER, slot: 3'd6, status: 8'h40, enabled: 1'b1,
              cycle_count: 32'd1, default: '0});
    add_row(DRIVER_ID_FIRST + 11'd3, DECODE_LENGTH, '0, 64'd12, 1'b0, '0);
    add_row(DRIVER_ID_FIRST + 11'd2, DECODE_LENGTH, 64'h00000000_00800000, 64'd13, 1'b0, '0);
    add_row(DRIVER_ID_FIRST - 11'd1, DECODE_LENGTH, '1, 64'd14, 1'b1,
            '{kind: KIND_IGNORED, cycle_count: 32'd1, default: '0});
    add_row(DRIVER_ID_LAST + 11'd1, DECODE_LENGTH, '1, 64'd15, 1'b1,
            '{kind: KIND_IGNORED, cycle_count: 32'd1, default: '0});
    add_row(DRIVER_ID_FIRST, 4'd9, '1, 64'd16, 1'b1,
            '{kind: KIND_IGNORED, cycle_count: 32'd1, default: '0});
    add_row(GRIPPER_ID_RST, DECODE_LENGTH, '1, 64'd17, 1'b1,
            '{kind: KIND_GRIPPER, value_first: 32'hFFFFFFFF, value_second: 32'd255,
              force_val: 16'hFFFF, status: 8'hFF, enabled: 1'b1, fault: 1'b1,
              homed: 1'b1, cycle_count: 32'd1, default: '0});
    add_row(GRIPPER_ID_RST, DECODE_LENGTH, 64'h00000000_00008000, 64'd18, 1'b0, '0);
    add_row(GRIPPER_ID_RST, DECODE_LENGTH, 64'h7FFFFFFF_1234407F, 64'd19, 1'b0, '0);
    add_row(GRIPPER_ID_RST, 4'd7, '1, 64'd20, 1'b1,
            '{kind: KIND_IGNORED, cycle_count: 32'd1, default: '0});
    add_row(PAIR12_ID_RST, DECODE_LENGTH, 64'h00000001_FFFFFFFE, 64'd21, 1'b0, '0);
    add_row(PAIR34_ID_RST, DECODE_LENGTH, 64'h7FFFFFFF_80000001, 64'd22, 1'b0, '0);
    add_row(PAIR56_ID_RST, DECODE_LENGTH, 64'hA5A5A5A5_5A5A5A5A, 64'd23, 1'b0, '0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[k]) send_frame(directed_rows[k]);
    hold_off_request = 1'b1;
    run_random(100);
    drain_results();

    set_ids(11'h000, 11'h7FF, DRIVER_ID_FIRST + 11'd2, 11'h555, 11'h2AA);
    run_random(100);
    drain_results();

    set_ids(11'h100, 11'h100, 11'h101, DRIVER_ID_LAST, DRIVER_ID_FIRST);
    run_random(100);
    drain_results();

    set_ids(11'h7FF, 11'h400, 11'h3FF, 11'h001, 11'h7FE);
    run_random(40);
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    run_random(60);
    drain_results();

    $display("Covered %0d joint, %0d driver, %0d gripper and %0d ignored frames",
             kind_count[KIND_JOINT], kind_count[KIND_DRIVER],
             kind_count[KIND_GRIPPER], kind_count[KIND_IGNORED]);
    $display("under four id settings, %0d position cycles completed", cycles_done);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
